@@ hw/rtl/u8d_pkg.sv @@
package u8d_pkg;

  localparam int unsigned ByteW = 8;
  localparam int unsigned CpW   = 21;
  localparam int unsigned PendW = 2;

  // bits of payload carried by one continuation byte
  localparam int unsigned ContBits = 6;

  // lead byte prefixes
  localparam logic [2:0] Lead2Prefix = 3'b110;
  localparam logic [3:0] Lead3Prefix = 4'b1110;

  // continuation bytes still expected after each lead form
  localparam logic [PendW-1:0] PendNone  = 2'd0;
  localparam logic [PendW-1:0] PendAfter2 = 2'd1;
  localparam logic [PendW-1:0] PendAfter3 = 2'd2;
  localparam logic [PendW-1:0] PendAfter4 = 2'd3;

  // result of one decode step, from core to top
  typedef struct packed {
    logic           emit;
    logic [CpW-1:0] code_point;
  } u8d_res_t;

endpackage

@@ hw/rtl/u8d_core.sv @@
module u8d_core (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      step_en,
  input  logic [u8d_pkg::ByteW-1:0] byte_in,
  output u8d_pkg::u8d_res_t         res
);

  logic [u8d_pkg::PendW-1:0] bytes_pending;
  logic [u8d_pkg::PendW-1:0] bytes_pending_next;
  logic [u8d_pkg::CpW-1:0]   partial_point;
  logic [u8d_pkg::CpW-1:0]   partial_point_next;
  logic [u8d_pkg::CpW-1:0]   shifted;
  logic [u8d_pkg::PendW-1:0] pend_dec;

  // partial code point with the next six payload bits shifted in
  assign shifted  = {partial_point[u8d_pkg::CpW-u8d_pkg::ContBits-1:0],
                     byte_in[u8d_pkg::ContBits-1:0]};
  assign pend_dec = bytes_pending - 2'd1;

  // decode one byte against the open sequence
  always_comb begin
    res.emit           = 1'b0;
    res.code_point     = '0;
    bytes_pending_next = bytes_pending;
    partial_point_next = partial_point;
    if (bytes_pending == u8d_pkg::PendNone) begin
      if (!byte_in[7]) begin
        // single byte word
        res.emit       = 1'b1;
        res.code_point = {13'd0, byte_in};
      end else if (byte_in[7:5] == u8d_pkg::Lead2Prefix) begin
        partial_point_next = {16'd0, byte_in[4:0]};
        bytes_pending_next = u8d_pkg::PendAfter2;
      end else if (byte_in[7:4] == u8d_pkg::Lead3Prefix) begin
        partial_point_next = {17'd0, byte_in[3:0]};
        bytes_pending_next = u8d_pkg::PendAfter3;
      end else begin
        // four byte lead, also stray continuation and f8-ff
        partial_point_next = {18'd0, byte_in[2:0]};
        bytes_pending_next = u8d_pkg::PendAfter4;
      end
    end else begin
      // continuation, not checked
      bytes_pending_next = pend_dec;
      if (pend_dec == u8d_pkg::PendNone) begin
        res.emit           = 1'b1;
        res.code_point     = shifted;
        partial_point_next = '0;
      end else begin
        partial_point_next = shifted;
      end
    end
  end

  // sequence state
  always_ff @(posedge clk) begin
    if (rst) begin
      bytes_pending <= u8d_pkg::PendNone;
      partial_point <= '0;
    end else if (step_en) begin
      bytes_pending <= bytes_pending_next;
      partial_point <= partial_point_next;
    end
  end

  // partial value never outgrows what the open sequence allows
  a_idle_clear: assert property (@(posedge clk) disable iff (rst)
    bytes_pending == u8d_pkg::PendNone |-> partial_point == '0)
    else $error("partial point not cleared with no open sequence");

  a_partial_bound: assert property (@(posedge clk) disable iff (rst)
    (bytes_pending != u8d_pkg::PendAfter4 || partial_point[20:3] == '0) &&
    (bytes_pending != u8d_pkg::PendAfter3 || partial_point[20:9] == '0) &&
    (bytes_pending != u8d_pkg::PendAfter2 || partial_point[20:15] == '0))
    else $error("partial point wider than the open sequence allows");

endmodule

@@ hw/rtl/utf8_byte_stream_decoder_unit.sv @@
// a byte is held in the input register, and the code point it completes goes to the result register
// throughput: one byte per cycle while the output side keeps up
// a byte that completes no code point never waits on out_ready
// the single decode step sits between the input register and the result register
// reset (rst, synchronous) empties both registers and closes any open sequence
module utf8_byte_stream_decoder_unit (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [u8d_pkg::ByteW-1:0] in_byte,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [u8d_pkg::CpW-1:0]   code_point
);

  logic                      in_q_valid;
  logic [u8d_pkg::ByteW-1:0] in_q_byte;
  logic                      advance;
  u8d_pkg::u8d_res_t         res;

  u8d_core u_core (
    .clk     (clk),
    .rst     (rst),
    .step_en (advance),
    .byte_in (in_q_byte),
    .res     (res)
  );

  // step moves when the result slot is free or nothing is emitted
  assign advance  = in_q_valid && (!res.emit || !out_valid || out_ready);
  assign in_ready = !in_q_valid || advance;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_q_valid <= 1'b0;
    end else if (in_ready) begin
      in_q_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_q_byte <= in_byte;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance && res.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && res.emit) begin
      code_point <= res.code_point;
    end
  end

  a_emit_lands: assert property (@(posedge clk) disable iff (rst)
    advance && res.emit |=> out_valid)
    else $error("emitted code point did not reach the result register");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready && res.emit |-> !advance)
    else $error("pending word overwritten in the result register");

  a_empty_ready: assert property (@(posedge clk) disable iff (rst)
    !in_q_valid |-> in_ready)
    else $error("input register empty but not ready");

endmodule

@@ bench/testbench.sv @@
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CycleLimit    = 200000;
  localparam int BytesPerPhase = 340;
  localparam int DrainCycles   = 10;
  localparam int NumPhases     = 4;
  localparam int ReportMax     = 10;

  logic                        clk       = 1'b0;
  logic                        rst       = 1'b1;
  logic                        in_valid  = 1'b0;
  logic                        in_ready;
  logic [u8d_pkg::ByteW-1:0]   in_byte   = '0;
  logic                        out_valid;
  logic                        out_ready = 1'b0;
  logic [u8d_pkg::CpW-1:0]     code_point;

  // bytes still to be sent and code points still to arrive
  logic [u8d_pkg::ByteW-1:0]   stream_bytes[$];
  logic [u8d_pkg::CpW-1:0]     expected_points[$];

  // decoder state as predicted from the accepted bytes
  logic [u8d_pkg::PendW-1:0]   cont_left = u8d_pkg::PendNone;
  logic [u8d_pkg::CpW-1:0]     point_acc = '0;

  logic                        point_done;
  logic [u8d_pkg::CpW-1:0]     point_value;
  logic [u8d_pkg::CpW-1:0]     oldest_point;

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int fail_count     = 0;
  int cycle_count    = 0;

  utf8_byte_stream_decoder_unit u_dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_byte    (in_byte),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .code_point (code_point)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // one decode step on the predicted state
  function automatic void decode_byte(input logic [u8d_pkg::ByteW-1:0] b, output logic done,
                                      output logic [u8d_pkg::CpW-1:0] cp);
    done = 1'b0;
    cp   = '0;
    if (cont_left == u8d_pkg::PendNone) begin
      if (!b[u8d_pkg::ByteW-1]) begin
        done = 1'b1;
        cp   = {13'd0, b};
      end else if (b[7:5] == u8d_pkg::Lead2Prefix) begin
        point_acc = {16'd0, b[4:0]};
        cont_left = u8d_pkg::PendAfter2;
      end else if (b[7:4] == u8d_pkg::Lead3Prefix) begin
        point_acc = {17'd0, b[3:0]};
        cont_left = u8d_pkg::PendAfter3;
      end else begin
        // stray continuation and F8-FF leads fall here too
        point_acc = {18'd0, b[2:0]};
        cont_left = u8d_pkg::PendAfter4;
      end
    end else begin
      // any byte inside a sequence counts as a continuation
      point_acc = {point_acc[u8d_pkg::CpW-1-u8d_pkg::ContBits:0], b[u8d_pkg::ContBits-1:0]};
      cont_left = cont_left - 1'b1;
      if (cont_left == u8d_pkg::PendNone) begin
        done      = 1'b1;
        cp        = point_acc;
        point_acc = '0;
      end
    end
  endfunction

  task automatic note_failure(input string what, input logic [u8d_pkg::CpW-1:0] exp_cp,
                              input logic [u8d_pkg::CpW-1:0] act_cp);
    if (fail_count < ReportMax)
      $display("error: %s code point, expected %06h got %06h", what, exp_cp, act_cp);
    fail_count++;
  endtask

  // one random sequence: mostly well formed, some noise and cut-off sequences
  task automatic push_random_seq(inout int added);
    int                         roll;
    int                         len;
    int                         conts;
    logic [u8d_pkg::ByteW-1:0]  lead;
    roll = $urandom_range(99);
    if (roll < 15) begin
      stream_bytes = {stream_bytes, 8'($urandom_range(255))};
      added++;
    end else begin
      len = $urandom_range(1, 4);
      case (len)
        1: lead = {1'b0, 7'($urandom)};
        2: lead = {u8d_pkg::Lead2Prefix, 5'($urandom)};
        3: lead = {u8d_pkg::Lead3Prefix, 4'($urandom)};
        default: lead = {5'b11110, 3'($urandom)};
      endcase
      conts = len - 1;
      if (roll < 22 && conts > 0)
        conts = $urandom_range(conts - 1);
      stream_bytes = {stream_bytes, lead};
      added++;
      for (int i = 0; i < conts; i++) begin
        stream_bytes = {stream_bytes, {2'b10, 6'($urandom)}};
        added++;
      end
    end
  endtask

  // driver: predict on each accepted word, then present the next one
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        decode_byte(in_byte, point_done, point_value);
        if (point_done)
          expected_points = {expected_points, point_value};
      end
      if (!in_valid || in_ready) begin
        if (stream_bytes.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          in_valid <= 1'b1;
          in_byte  <= stream_bytes.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor: compare each accepted word with the oldest prediction
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (expected_points.size() == 0) begin
        note_failure("unexpected", '0, code_point);
      end else begin
        oldest_point = expected_points.pop_front();
        if (code_point !== oldest_point)
          note_failure("wrong", oldest_point, code_point);
      end
    end
    out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    int added;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    for (int phase = 0; phase < NumPhases; phase++) begin
      @(negedge clk);
      case (phase)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 82; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 82; end
        default: begin send_idle_pct = 22; recv_stall_pct = 22; end
      endcase
      if (phase == 0) begin
        // ascii extremes, two and three byte forms, largest four byte point,
        // stray continuation lead with ascii and lead bytes inside,
        // FF lead, overlong form, surrogate
        stream_bytes = {8'h00, 8'h7F, 8'hC2, 8'hA9, 8'hEF, 8'hBF, 8'hBF,
                        8'hF7, 8'hBF, 8'hBF, 8'hBF, 8'h80, 8'h41, 8'hC3, 8'hFF,
                        8'hFF, 8'h00, 8'h00, 8'h00, 8'hC0, 8'h80,
                        8'hED, 8'hA0, 8'h80};
      end
      added = 0;
      while (added < BytesPerPhase)
        push_random_seq(added);
      while (stream_bytes.size() != 0 || in_valid || expected_points.size() != 0)
        @(negedge clk);
    end
    repeat (DrainCycles) @(negedge clk);
    if (fail_count == 0 && expected_points.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
